[hw/rtl/tom_pkg.sv]
`timescale 1ns / 1ps

package tom_pkg;

    // Default structure sizes
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;

    // Field widths fixed by the interface
    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = 32;
    localparam int VOLUME_W    = 15;
    localparam int COUNT_W     = 16;
    localparam int WAVE_W      = 17;   // wave value, -32768..32768
    localparam int ROM_DATA_W  = 15;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_TRIM  = 2'd3;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAW      = 2'd3
    } t_wave;

    // Register reset values
    localparam logic [STEP_W-1:0]          PHASE_STEP_RST = 32'd42852281;
    localparam logic signed [VOLUME_W-1:0] VOLUME_RST     = 15'sd10000;
    localparam t_wave                      WAVEFORM_RST   = WAVE_SINE;
    localparam logic                       TAIL_TRIM_RST  = 1'b1;

    // Sine table generation, Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    // Output scaling: divisor 327680000 = 625 << 19
    localparam int          DIV_SHIFT   = 19;
    localparam int          MIX_W       = 48;
    localparam int          QUOT_IN_W   = 25;
    localparam logic [28:0] QUOT_LIMIT  = 29'd20480000;   // 32768 * 625
    localparam logic [QUOT_IN_W-1:0] RECIP_625 = 25'd27487791; // ceil(2^34 / 625)
    localparam int          RECIP_SHIFT = 34;

    // Per-stage load strobes of the datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_adv;

endpackage

[hw/rtl/tom_phase.sv]
`timescale 1ns / 1ps

module tom_phase #(
    parameter int PHASE_BITS = tom_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tom_pkg::t_adv                     i_adv,
    input  logic [tom_pkg::STEP_W-1:0]        i_phase_step,
    input  logic                              i_tail_trim,
    input  logic                              i_last_channel,
    input  logic                              i_frame_start,
    input  logic [tom_pkg::STEP_W-1:0]        i_start_phase,
    input  logic                              i_final_frame,
    input  logic [tom_pkg::COUNT_W-1:0]       i_samples_to_end,
    output logic [PHASE_BITS-1:0]             o_phase1,
    output logic                              o_stop3
);

    localparam int PROD_W = PHASE_BITS + tom_pkg::COUNT_W;

    logic [PHASE_BITS-1:0]          r_phase;
    logic                           r_stopped;
    logic [PHASE_BITS-1:0]          n_phase_used;
    logic [PHASE_BITS-1:0]          n_step;

    logic [PHASE_BITS-1:0]          r1_phase;
    logic                           r1_fs;
    logic                           r1_chk;
    logic [tom_pkg::COUNT_W-1:0]    r1_n;

    logic [PHASE_BITS-1:0]          r2_phase;
    logic                           r2_fs;
    logic                           r2_chk;
    logic [PROD_W-1:0]              r2_prod;

    logic [PROD_W:0]                n_reach;
    logic                           n_stop;
    logic                           r3_stop;

    assign n_step       = PHASE_BITS'(i_phase_step);
    assign n_phase_used = i_frame_start ? PHASE_BITS'(i_start_phase) : r_phase;

    // Phase state advances at accept time so the next item sees it at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_adv.s1) begin
            r_phase <= i_last_channel ? n_phase_used + n_step : n_phase_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r1_phase <= n_phase_used;
            r1_fs    <= i_frame_start;
            r1_chk   <= i_final_frame & i_tail_trim;
            r1_n     <= i_samples_to_end;
        end
        if (i_adv.s2) begin
            r2_phase <= r1_phase;
            r2_fs    <= r1_fs;
            r2_chk   <= r1_chk;
            r2_prod  <= PROD_W'(r1_n) * PROD_W'(n_step);
        end
    end

    // Period cannot finish when phase + n * step stays below one full turn
    assign n_reach = (PROD_W + 1)'(r2_phase) + (PROD_W + 1)'(r2_prod);
    assign n_stop  = (r2_fs ? 1'b0 : r_stopped) |
                     (r2_chk & (n_reach[PROD_W:PHASE_BITS] == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else if (i_adv.s3) begin
            r_stopped <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r3_stop <= n_stop;
        end
    end

    assign o_phase1 = r1_phase;
    assign o_stop3  = r3_stop;

endmodule

[hw/rtl/tom_wave.sv]
`timescale 1ns / 1ps

module tom_wave #(
    parameter int SINE_TABLE_BITS = tom_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = tom_pkg::PHASE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  tom_pkg::t_adv                        i_adv,
    input  tom_pkg::t_wave                       i_waveform,
    input  logic [PHASE_BITS-1:0]                i_phase1,
    output logic signed [tom_pkg::WAVE_W-1:0]    o_wave3
);

    localparam int ROM_N = 1 << SINE_TABLE_BITS;
    localparam int IDX_W = SINE_TABLE_BITS + 1;

    typedef logic [tom_pkg::ROM_DATA_W-1:0] t_rom [ROM_N+1];

    // Quarter-wave table, Taylor series to 11th order in Q30
    function automatic t_rom build_sine();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k <= ROM_N; k++) begin
            x  = (tom_pkg::HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            r  = tom_pkg::Q30_ONE - x2 / 64'd110;
            r  = tom_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd72;
            r  = tom_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd42;
            r  = tom_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd20;
            r  = tom_pkg::Q30_ONE - ((x2 * r) >> 30) / 64'd6;
            s  = (x * r) >> 30;
            e  = (s * tom_pkg::FULL_SCALE + (tom_pkg::Q30_ONE >> 1)) >> 30;
            if (e > tom_pkg::FULL_SCALE) begin
                e = tom_pkg::FULL_SCALE;
            end
            rom[k] = e[tom_pkg::ROM_DATA_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_sine();

    logic [PHASE_BITS+15:0]              n_pext;
    logic [16:0]                         n_u;
    logic signed [17:0]                  n_us;
    logic [1:0]                          n_quad;
    logic [SINE_TABLE_BITS-1:0]          n_raw;
    logic [IDX_W-1:0]                    n_idx;
    logic signed [tom_pkg::WAVE_W-1:0]   n_alt;

    logic [tom_pkg::ROM_DATA_W-1:0]      r2_sine;
    logic                                r2_neg;
    logic                                r2_is_sine;
    logic signed [tom_pkg::WAVE_W-1:0]   r2_alt;
    logic signed [tom_pkg::WAVE_W-1:0]   r3_wave;
    logic signed [tom_pkg::WAVE_W-1:0]   n_sine_s;

    // 17-bit phase fraction for the geometric waves
    assign n_pext = {i_phase1, 16'b0};
    assign n_u    = n_pext[PHASE_BITS+15 -: 17];
    assign n_us   = $signed({1'b0, n_u});

    assign n_quad = i_phase1[PHASE_BITS-1 -: 2];
    assign n_raw  = i_phase1[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign n_idx  = n_quad[0] ? IDX_W'(ROM_N) - {1'b0, n_raw} : {1'b0, n_raw};

    always_comb begin
        case (i_waveform)
            tom_pkg::WAVE_SQUARE: begin
                n_alt = n_u[16] ? -17'sd32768 : 17'sd32768;
            end
            tom_pkg::WAVE_TRIANGLE: begin
                if (n_u < 17'd32768) begin
                    n_alt = 17'(n_us);
                end else if (n_u < 17'd98304) begin
                    n_alt = 17'(18'sd65536 - n_us);
                end else begin
                    n_alt = 17'(n_us - 18'sd131072);
                end
            end
            tom_pkg::WAVE_SAW: begin
                n_alt = $signed({1'b0, n_u[16:1]}) - 17'sd32768;
            end
            default: begin
                n_alt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r2_sine    <= SINE_ROM[n_idx];
            r2_neg     <= n_quad[1];
            r2_is_sine <= (i_waveform == tom_pkg::WAVE_SINE);
            r2_alt     <= n_alt;
        end
    end

    assign n_sine_s = $signed({2'b0, r2_sine});

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            if (r2_is_sine) begin
                r3_wave <= r2_neg ? -n_sine_s : n_sine_s;
            end else begin
                r3_wave <= r2_alt;
            end
        end
    end

    assign o_wave3 = r3_wave;

endmodule

[hw/rtl/tom_mix.sv]
`timescale 1ns / 1ps

module tom_mix (
    input  logic                                   i_clk,
    input  tom_pkg::t_adv                          i_adv,
    input  logic signed [tom_pkg::VOLUME_W-1:0]    i_volume,
    input  logic signed [tom_pkg::WAVE_W-1:0]      i_wave3,
    input  logic                                   i_stop3,
    input  logic signed [tom_pkg::SAMPLE_W-1:0]    i_sample3,
    output logic signed [tom_pkg::SAMPLE_W-1:0]    o_sample_out
);

    localparam int MW = tom_pkg::MIX_W;
    localparam int QW = tom_pkg::QUOT_IN_W;
    localparam int PW = 2 * QW;

    logic signed [31:0]                    r4_prod;
    logic                                  r4_stop;
    logic signed [tom_pkg::SAMPLE_W-1:0]   r4_sample;

    logic signed [MW-1:0]                  n_num;
    logic signed [MW-1:0]                  n_base;
    logic signed [MW-1:0]                  n_tot;
    logic [MW-1:0]                         n_mag;
    logic [MW-tom_pkg::DIV_SHIFT-1:0]      n_a;

    logic [QW-1:0]                         r5_a;
    logic                                  r5_neg;
    logic                                  r5_stop;
    logic signed [tom_pkg::SAMPLE_W-1:0]   r5_sample;

    logic [PW-1:0]                         n_qprod;
    logic [15:0]                           n_q;
    logic signed [16:0]                    n_res;

    logic signed [tom_pkg::SAMPLE_W-1:0]   r6_out;

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r4_prod   <= 32'(i_wave3) * 32'(i_volume);
            r4_stop   <= i_stop3;
            r4_sample <= i_sample3;
        end
    end

    // total = sample * 327680000 + wave * volume * 32767
    assign n_num  = (MW'(r4_prod) <<< 15) - MW'(r4_prod);
    assign n_base = (MW'(r4_sample) * 48'sd625) <<< tom_pkg::DIV_SHIFT;
    assign n_tot  = n_base + n_num;
    assign n_mag  = n_tot[MW-1] ? MW'(-n_tot) : MW'(n_tot);
    assign n_a    = n_mag[MW-1:tom_pkg::DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r5_a      <= (n_a >= tom_pkg::QUOT_LIMIT) ? QW'(tom_pkg::QUOT_LIMIT) : QW'(n_a);
            r5_neg    <= n_tot[MW-1];
            r5_stop   <= r4_stop;
            r5_sample <= r4_sample;
        end
    end

    // Divide by 625 through the reciprocal; exact for the clamped range
    assign n_qprod = PW'(r5_a) * PW'(tom_pkg::RECIP_625);
    assign n_q     = n_qprod[tom_pkg::RECIP_SHIFT +: 16];

    always_comb begin
        if (r5_neg) begin
            n_res = -$signed({1'b0, n_q});
        end else if (n_q > 16'd32767) begin
            n_res = 17'sd32767;
        end else begin
            n_res = $signed({1'b0, n_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s6) begin
            r6_out <= r5_stop ? r5_sample : n_res[15:0];
        end
    end

    assign o_sample_out = r6_out;

endmodule

[hw/rtl/tone_oscillator_mixer.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while i_out_ready lets results move on,
//   set by the six-stage datapath, with stage 6 driving o_out_valid and the
//   phase accumulator closing its loop in the input stage.
// Reset (i_rst_n, synchronous, active low): phase and stop latch cleared, pipeline
//   emptied, registers back to step 42852281, volume 10000, sine, tail trim on.
module tone_oscillator_mixer #(
    parameter int SINE_TABLE_BITS = tom_pkg::SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = tom_pkg::PHASE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [tom_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [tom_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    // sample input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [tom_pkg::SAMPLE_W-1:0]     i_sample_in,
    input  logic                                    i_last_channel,
    input  logic                                    i_frame_start,
    input  logic [tom_pkg::STEP_W-1:0]              i_start_phase,
    input  logic                                    i_final_frame,
    input  logic [tom_pkg::COUNT_W-1:0]             i_samples_to_end,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [tom_pkg::SAMPLE_W-1:0]     o_sample_out,
    output logic                                    o_last_channel_out
);

    // Configuration registers
    logic [tom_pkg::STEP_W-1:0]            r_phase_step;
    logic signed [tom_pkg::VOLUME_W-1:0]   r_volume;
    tom_pkg::t_wave                        r_waveform;
    logic                                  r_tail_trim;

    // Pipeline control: one valid bit per stage, stage 6 is the output register
    logic [6:1]                            r_vld;
    logic [6:1]                            n_en;
    tom_pkg::t_adv                         n_adv;

    // Side payload carried alongside the datapath
    logic signed [tom_pkg::SAMPLE_W-1:0]   r_samp1;
    logic signed [tom_pkg::SAMPLE_W-1:0]   r_samp2;
    logic signed [tom_pkg::SAMPLE_W-1:0]   r_samp3;
    logic [6:1]                            r_last;

    logic [PHASE_BITS-1:0]                 n_phase1;
    logic                                  n_stop3;
    logic signed [tom_pkg::WAVE_W-1:0]     n_wave3;

    // Registers take a write in any cycle; writes land only while idle by contract.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= tom_pkg::PHASE_STEP_RST;
            r_volume     <= tom_pkg::VOLUME_RST;
            r_waveform   <= tom_pkg::WAVEFORM_RST;
            r_tail_trim  <= tom_pkg::TAIL_TRIM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tom_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                tom_pkg::CFG_VOLUME:     r_volume     <= $signed(i_cfg_data[14:0]);
                tom_pkg::CFG_WAVEFORM:   r_waveform   <= tom_pkg::t_wave'(i_cfg_data[1:0]);
                tom_pkg::CFG_TAIL_TRIM:  r_tail_trim  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its item moves on; bubbles collapse,
    // so new transactions come in while a result waits, until all stages fill.
    assign n_en[6] = !r_vld[6] || i_out_ready;
    assign n_en[5] = !r_vld[5] || n_en[6];
    assign n_en[4] = !r_vld[4] || n_en[5];
    assign n_en[3] = !r_vld[3] || n_en[4];
    assign n_en[2] = !r_vld[2] || n_en[3];
    assign n_en[1] = !r_vld[1] || n_en[2];

    assign n_adv.s1 = i_in_valid && n_en[1];
    assign n_adv.s2 = r_vld[1] && n_en[2];
    assign n_adv.s3 = r_vld[2] && n_en[3];
    assign n_adv.s4 = r_vld[3] && n_en[4];
    assign n_adv.s5 = r_vld[4] && n_en[5];
    assign n_adv.s6 = r_vld[5] && n_en[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            if (n_en[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (n_en[3]) begin
                r_vld[3] <= r_vld[2];
            end
            if (n_en[4]) begin
                r_vld[4] <= r_vld[3];
            end
            if (n_en[5]) begin
                r_vld[5] <= r_vld[4];
            end
            if (n_en[6]) begin
                r_vld[6] <= r_vld[5];
            end
        end
    end

    // Sample follows the datapath up to the mixer; channel flag to the output
    always_ff @(posedge i_clk) begin
        if (n_adv.s1) begin
            r_samp1   <= i_sample_in;
            r_last[1] <= i_last_channel;
        end
        if (n_adv.s2) begin
            r_samp2   <= r_samp1;
            r_last[2] <= r_last[1];
        end
        if (n_adv.s3) begin
            r_samp3   <= r_samp2;
            r_last[3] <= r_last[2];
        end
        if (n_adv.s4) begin
            r_last[4] <= r_last[3];
        end
        if (n_adv.s5) begin
            r_last[5] <= r_last[4];
        end
        if (n_adv.s6) begin
            r_last[6] <= r_last[5];
        end
    end

    // Phase accumulator, frame reload and tail-trim stop latch
    tom_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (n_adv),
        .i_phase_step     (r_phase_step),
        .i_tail_trim      (r_tail_trim),
        .i_last_channel   (i_last_channel),
        .i_frame_start    (i_frame_start),
        .i_start_phase    (i_start_phase),
        .i_final_frame    (i_final_frame),
        .i_samples_to_end (i_samples_to_end),
        .o_phase1         (n_phase1),
        .o_stop3          (n_stop3)
    );

    // Tone value: sine ROM or computed square, triangle, sawtooth
    tom_wave #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_wave (
        .i_clk      (i_clk),
        .i_adv      (n_adv),
        .i_waveform (r_waveform),
        .i_phase1   (n_phase1),
        .o_wave3    (n_wave3)
    );

    // Volume scaling, truncating divide, saturation, stop bypass
    tom_mix u_mix (
        .i_clk        (i_clk),
        .i_adv        (n_adv),
        .i_volume     (r_volume),
        .i_wave3      (n_wave3),
        .i_stop3      (n_stop3),
        .i_sample3    (r_samp3),
        .o_sample_out (o_sample_out)
    );

    assign o_in_ready         = n_en[1];
    assign o_out_valid        = r_vld[6];
    assign o_last_channel_out = r_last[6];

endmodule

[hw/rtl/tom_chk.sv]
`timescale 1ns / 1ps

module tom_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 i_last_channel,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [tom_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic                                 o_last_channel_out
);

    logic n_acc;

    assign n_acc = i_in_valid && o_in_ready;

    // An empty output register never blocks the input side
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side can move");

    // With the output always taking, each accepted transaction reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready |=>
        o_out_valid && (o_last_channel_out == $past(i_last_channel, 6)))
        else $error("result missing or out of order after pipeline latency");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_sample_out) && $stable(o_last_channel_out)))
        else $error("result changed while stalled");

endmodule

bind tone_oscillator_mixer tom_chk u_tom_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_last_channel     (i_last_channel),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_sample_out       (o_sample_out),
    .o_last_channel_out (o_last_channel_out)
);
